// ===== src/csr_sparse_matrix_vector_multiply_assert.svh =====
// assertion macros used by the top-level file to check timing properties
`ifndef CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SMV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smv same-cycle check failed");

// next-cycle implication, checked outside reset
`define SMV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smv next-cycle check failed");

`endif

// ===== src/smv_pkg.sv =====
package smv_pkg;

    // fixed field widths
    localparam int COL_W      = 10;
    localparam int ROW_IDX_W  = 10;
    localparam int VAL_W      = 32;
    localparam int ACC_W      = 48;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int FRAC_W     = 16;
    localparam int IDX_EXT_W  = 17;

    // defaults for the top-level parameters
    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;
    localparam int Q_DEPTH_DEF  = 4;

    // request codes on the input channel
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_NONZERO = 2'd1;
    localparam logic [1:0] REQ_EMPTY   = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    // operations passed from the front end to the back end
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_MAC   = 2'd1,
        OP_EMPTY = 2'd2
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic                    last;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] x;
    } q_word_t;

endpackage

// ===== src/smv_in_if.sv =====
interface smv_in_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [9:0]            col_index;
    logic signed [31:0]    elem_value;
    logic                  row_last;

    modport source (output valid, output req_type, output col_index,
                    output elem_value, output row_last, input ready);
    modport sink   (input valid, input req_type, input col_index,
                    input elem_value, input row_last, output ready);
endinterface

// ===== src/smv_out_if.sv =====
interface smv_out_if;
    logic                  valid;
    logic                  ready;
    logic [9:0]            row_index;
    logic signed [47:0]    row_sum;

    modport source (output valid, output row_index, output row_sum, input ready);
    modport sink   (input valid, input row_index, input row_sum, output ready);
endinterface

// ===== src/smv_front.sv =====
module smv_front #(
    parameter int MAX_COLS = smv_pkg::MAX_COLS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    smv_in_if.sink           item,
    input  logic             q_full,
    output logic             q_push,
    output smv_pkg::q_word_t q_wdata
);
    localparam int ADDR_W = $clog2(MAX_COLS);

    logic signed [smv_pkg::VAL_W-1:0] vec_mem [MAX_COLS];

    logic                             accept;
    logic                             keep;
    smv_pkg::op_t                     op_dec;
    logic                             col_ok;
    logic [smv_pkg::IDX_EXT_W-1:0]    col_ext;
    logic [ADDR_W-1:0]                addr;

    logic                             s1_valid_reg, s1_valid_next;
    smv_pkg::op_t                     s1_op_reg;
    logic                             s1_last_reg;
    logic                             s1_col_ok_reg;
    logic signed [smv_pkg::VAL_W-1:0] s1_value_reg;
    logic signed [smv_pkg::VAL_W-1:0] rd_data_reg;

    assign col_ext    = smv_pkg::IDX_EXT_W'(item.col_index);
    assign addr       = col_ext[ADDR_W-1:0];
    assign col_ok     = (int'(col_ext) < MAX_COLS);
    assign q_push     = s1_valid_reg && !q_full;
    assign item.ready = !s1_valid_reg || !q_full;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        keep   = 1'b1;
        op_dec = smv_pkg::OP_CLEAR;
        unique case (item.req_type)
            smv_pkg::REQ_LOAD:    op_dec = smv_pkg::OP_CLEAR;
            smv_pkg::REQ_NONZERO: op_dec = smv_pkg::OP_MAC;
            smv_pkg::REQ_EMPTY:   op_dec = smv_pkg::OP_EMPTY;
            default:              keep   = 1'b0;
        endcase
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept && keep)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // vector store: written by loads, read registered for nonzeros
    always_ff @(posedge clk)
    begin
        if (accept && item.req_type == smv_pkg::REQ_LOAD && col_ok)
        begin
            vec_mem[addr] <= item.elem_value;
        end
        if (accept)
        begin
            rd_data_reg <= vec_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            s1_op_reg     <= op_dec;
            s1_last_reg   <= item.row_last;
            s1_col_ok_reg <= col_ok;
            s1_value_reg  <= item.elem_value;
        end
    end

    // out-of-range columns contribute nothing
    always_comb
    begin
        q_wdata.op    = s1_op_reg;
        q_wdata.last  = s1_last_reg;
        q_wdata.value = s1_value_reg;
        q_wdata.x     = s1_col_ok_reg ? rd_data_reg : '0;
    end

endmodule

// ===== src/smv_fifo.sv =====
module smv_fifo #(
    parameter int DEPTH = smv_pkg::Q_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  smv_pkg::q_word_t wdata,
    input  logic             pop,
    output smv_pkg::q_word_t rdata,
    output logic             full,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    smv_pkg::q_word_t  slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== src/smv_back.sv =====
module smv_back #(
    parameter int MAX_ROWS = smv_pkg::MAX_ROWS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  smv_pkg::q_word_t q_rdata,
    output logic             q_pop,
    smv_out_if.source        result
);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int ACC_W = smv_pkg::ACC_W;

    logic signed [smv_pkg::PROD_W-1:0] product;

    logic                     b1_valid_reg, b1_valid_next;
    smv_pkg::op_t             b1_op_reg;
    logic                     b1_last_reg;
    logic signed [ACC_W-1:0]  b1_prod_reg;

    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [ROW_W-1:0]         row_cnt_reg, row_cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic [smv_pkg::ROW_IDX_W-1:0] out_index_reg;
    logic signed [ACC_W-1:0]  out_sum_reg;

    logic                     emit;
    logic                     consume;
    logic signed [ACC_W:0]    sum_wide;
    logic signed [ACC_W-1:0]  sum_sat;
    logic signed [ACC_W-1:0]  emit_sum;
    logic [ROW_W-1:0]         row_cnt_inc;
    logic [smv_pkg::IDX_EXT_W-1:0] row_cnt_ext;

    // floor to q32.16 is the upper bits of the full product
    assign product = q_rdata.value * q_rdata.x;

    always_comb
    begin
        emit = 1'b0;
        unique case (b1_op_reg)
            smv_pkg::OP_MAC:   emit = b1_last_reg;
            smv_pkg::OP_EMPTY: emit = 1'b1;
            default:           emit = 1'b0;
        endcase
    end

    assign consume = b1_valid_reg && (!emit || !out_valid_reg || result.ready);
    assign q_pop   = !q_empty && (!b1_valid_reg || consume);

    // saturating accumulate
    assign sum_wide = {acc_reg[ACC_W-1], acc_reg} + {b1_prod_reg[ACC_W-1], b1_prod_reg};
    always_comb
    begin
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1])
        begin
            sum_sat = sum_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[ACC_W-1:0];
        end
    end

    assign row_cnt_inc = (row_cnt_reg == ROW_W'(MAX_ROWS - 1)) ? '0 : row_cnt_reg + 1'b1;
    assign row_cnt_ext = smv_pkg::IDX_EXT_W'(row_cnt_reg);

    always_comb
    begin
        acc_next     = acc_reg;
        row_cnt_next = row_cnt_reg;
        emit_sum     = '0;
        if (consume)
        begin
            unique case (b1_op_reg)
                smv_pkg::OP_CLEAR:
                begin
                    acc_next     = '0;
                    row_cnt_next = '0;
                end
                smv_pkg::OP_MAC:
                begin
                    emit_sum = sum_sat;
                    if (b1_last_reg)
                    begin
                        acc_next     = '0;
                        row_cnt_next = row_cnt_inc;
                    end
                    else
                    begin
                        acc_next = sum_sat;
                    end
                end
                smv_pkg::OP_EMPTY:
                begin
                    acc_next     = '0;
                    row_cnt_next = row_cnt_inc;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        b1_valid_next = b1_valid_reg;
        if (consume)
        begin
            b1_valid_next = 1'b0;
        end
        if (q_pop)
        begin
            b1_valid_next = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (consume && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            row_cnt_reg   <= '0;
        end
        else
        begin
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            row_cnt_reg   <= row_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_op_reg   <= q_rdata.op;
            b1_last_reg <= q_rdata.last;
            b1_prod_reg <= product[smv_pkg::PROD_W-1:smv_pkg::FRAC_W];
        end
        if (consume && emit)
        begin
            out_index_reg <= row_cnt_ext[smv_pkg::ROW_IDX_W-1:0];
            out_sum_reg   <= emit_sum;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.row_index = out_index_reg;
    assign result.row_sum   = out_sum_reg;

endmodule

// ===== src/csr_sparse_matrix_vector_multiply.sv =====
// sparse matrix times dense vector, rows streamed in compressed-row order
// item channel (valid/ready): req_type selects load vector entry, nonzero
//   or empty row; col_index, elem_value (signed q16.16) and row_last ride along
// result channel (valid/ready): row_index and the saturated 48-bit row_sum
// a word is taken at a rising edge with valid and ready both high
// one item per cycle sustained while the queue is not full; a row result follows
//   the word that ends the row through the store read, the queue, the multiply
//   register and the accumulate/output register
// loads write the vector store and clear the row counter and the sum
// reset clears the row counter, the sum and all valid flags; the vector
//   store holds garbage until loaded and needs no clearing pass
// a stalled result receiver backs up the back end first; the queue keeps
//   taking words until full, after which item ready drops
`include "csr_sparse_matrix_vector_multiply_assert.svh"

module csr_sparse_matrix_vector_multiply #(
    parameter int MAX_COLS = smv_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = smv_pkg::MAX_ROWS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    smv_in_if.sink    item,
    smv_out_if.source result
);
    localparam int Q_DEPTH = smv_pkg::Q_DEPTH_DEF;

    // front-to-back queue handshake
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    smv_pkg::q_word_t q_wdata;
    smv_pkg::q_word_t q_rdata;

    // front end: decode, vector store, store read
    smv_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    // decoupling queue
    smv_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    // back end: multiply, saturating accumulate, row counter, output register
    smv_back #(
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .result  (result)
    );

    // queue never written when full nor read when empty
    `SMV_ASSERT_NOW(a_no_overflow, clk, rst_n, q_push, !q_full)
    `SMV_ASSERT_NOW(a_no_underflow, clk, rst_n, q_pop, !q_empty)
    // an unused request code leaves nothing for the queue
    `SMV_ASSERT_NEXT(a_unused_dropped, clk, rst_n,
        item.valid && item.ready && item.req_type == smv_pkg::REQ_UNUSED, !q_push)

endmodule
